// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WVS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define WVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Holds in the cycle after reset is applied.
`define WVS_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wvs_pkg.sv =====
`timescale 1ns / 1ps

package wvs_pkg;

    localparam int A_W       = 18;
    localparam int B_W       = 44;
    localparam int P_W       = A_W + B_W;
    localparam int MAC_W     = 66;
    localparam int T_W       = 37;
    localparam int S_W       = 42;
    localparam int ACC_W     = 48;
    localparam int OUT_W     = 32;
    localparam int T_SHIFT   = 13;
    localparam int S_SHIFT   = 14;
    localparam int ACC_SHIFT = 16;
    localparam int N_STEPS   = 28;
    localparam int STEP_W    = $clog2(N_STEPS);

    typedef struct packed {
        logic signed [31:0] joint_pos_x;
        logic signed [31:0] joint_pos_y;
        logic signed [31:0] joint_pos_z;
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [15:0] rot_w;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic        [16:0] bias;
        logic               is_last;
    } t_in_data;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_out_data;

    typedef enum logic [2:0] {A_QX, A_QY, A_QZ, A_QW, A_K, A_BIAS} t_a_sel;
    typedef enum logic [3:0] {
        B_OX, B_OY, B_OZ, B_JX, B_JY, B_JZ, B_TX, B_TY, B_TZ, B_S
    } t_b_sel;
    typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_ADD, OP_SUB} t_op;
    typedef enum logic [2:0] {BASE_T, BASE_S, BASE_AX, BASE_AY, BASE_AZ} t_base;
    typedef enum logic [2:0] {
        WB_NONE, WB_TX, WB_TY, WB_TZ, WB_S, WB_AX, WB_AY, WB_AZ
    } t_wb;

    typedef struct packed {
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_op    op;
        t_base  base;
        t_wb    wb;
    } t_uop;

    typedef struct packed {
        t_op op;
        t_wb wb;
    } t_mac_req;

    function automatic t_uop f_mk(input t_a_sel a, input t_b_sel b, input t_op op,
                                  input t_base base, input t_wb wb);
        t_uop u;
        u.a_sel = a;
        u.b_sel = b;
        u.op    = op;
        u.base  = base;
        u.wb    = wb;
        return u;
    endfunction

    // Microcode: at most one multiply issued per step, accumulated in the following cycle.
    function automatic t_uop f_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            5'd0:  u = f_mk(A_QY,   B_OZ, OP_LOAD, BASE_T,  WB_NONE);
            5'd1:  u = f_mk(A_QZ,   B_OY, OP_SUB,  BASE_T,  WB_TX);
            5'd2:  u = f_mk(A_QZ,   B_OX, OP_LOAD, BASE_T,  WB_NONE);
            5'd3:  u = f_mk(A_QX,   B_OZ, OP_SUB,  BASE_T,  WB_TY);
            5'd4:  u = f_mk(A_QX,   B_OY, OP_LOAD, BASE_T,  WB_NONE);
            5'd5:  u = f_mk(A_QY,   B_OX, OP_SUB,  BASE_T,  WB_TZ);
            5'd6:  u = f_mk(A_QW,   B_TX, OP_LOAD, BASE_S,  WB_NONE);
            5'd7:  u = f_mk(A_QY,   B_TZ, OP_ADD,  BASE_S,  WB_NONE);
            5'd8:  u = f_mk(A_QZ,   B_TY, OP_SUB,  BASE_S,  WB_NONE);
            5'd9:  u = f_mk(A_K,    B_OX, OP_ADD,  BASE_S,  WB_NONE);
            5'd10: u = f_mk(A_K,    B_JX, OP_ADD,  BASE_S,  WB_S);
            5'd12: u = f_mk(A_BIAS, B_S,  OP_LOAD, BASE_AX, WB_AX);
            5'd13: u = f_mk(A_QW,   B_TY, OP_LOAD, BASE_S,  WB_NONE);
            5'd14: u = f_mk(A_QZ,   B_TX, OP_ADD,  BASE_S,  WB_NONE);
            5'd15: u = f_mk(A_QX,   B_TZ, OP_SUB,  BASE_S,  WB_NONE);
            5'd16: u = f_mk(A_K,    B_OY, OP_ADD,  BASE_S,  WB_NONE);
            5'd17: u = f_mk(A_K,    B_JY, OP_ADD,  BASE_S,  WB_S);
            5'd19: u = f_mk(A_BIAS, B_S,  OP_LOAD, BASE_AY, WB_AY);
            5'd20: u = f_mk(A_QW,   B_TZ, OP_LOAD, BASE_S,  WB_NONE);
            5'd21: u = f_mk(A_QX,   B_TY, OP_ADD,  BASE_S,  WB_NONE);
            5'd22: u = f_mk(A_QY,   B_TX, OP_SUB,  BASE_S,  WB_NONE);
            5'd23: u = f_mk(A_K,    B_OZ, OP_ADD,  BASE_S,  WB_NONE);
            5'd24: u = f_mk(A_K,    B_JZ, OP_ADD,  BASE_S,  WB_S);
            5'd26: u = f_mk(A_BIAS, B_S,  OP_LOAD, BASE_AZ, WB_AZ);
            default: u = f_mk(A_QX, B_OX, OP_NONE, BASE_T,  WB_NONE);
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/wvs_stream_if.sv =====
`timescale 1ns / 1ps

interface wvs_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/wvs_mac.sv =====
`timescale 1ns / 1ps

module wvs_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [wvs_pkg::A_W-1:0]     i_a,
    input  logic signed [wvs_pkg::B_W-1:0]     i_b,
    input  logic signed [wvs_pkg::MAC_W-1:0]   i_base,
    input  wvs_pkg::t_mac_req                  i_req,
    output logic signed [wvs_pkg::MAC_W-1:0]   o_sum,
    output wvs_pkg::t_wb                       o_wb
);
    import wvs_pkg::*;

    logic signed [P_W-1:0]   r_prod;
    logic signed [MAC_W-1:0] r_base;
    logic signed [MAC_W-1:0] r_acc;
    t_mac_req                r_req;

    logic signed [MAC_W-1:0] w_prod_ext;
    logic        [MAC_W-1:0] w_addend;
    logic        [MAC_W-1:0] w_start;
    logic                    w_sub;
    logic        [MAC_W-1:0] n_acc;

    assign w_prod_ext = {{(MAC_W-P_W){r_prod[P_W-1]}}, r_prod};
    assign w_sub      = (r_req.op == OP_SUB);
    assign w_addend   = w_sub ? ~w_prod_ext : w_prod_ext;
    assign w_start    = (r_req.op == OP_LOAD) ? r_base : r_acc;
    assign n_acc      = w_start + w_addend + {{(MAC_W-1){1'b0}}, w_sub};

    assign o_sum = n_acc;
    assign o_wb  = r_req.wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '{op: OP_NONE, wb: WB_NONE};
        end else begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_base <= i_base;
        if (r_req.op != OP_NONE) begin
            r_acc <= n_acc;
        end
    end

endmodule

// ===== hdl/weighted_vertex_skinning_unit.sv =====
`timescale 1ns / 1ps

// Weighted vertex skinning unit.
// i_req carries one weight term per request: joint position, joint
// orientation quaternion (Q2.14), local offset, bias (Q1.16) and is_last.
// o_rsp carries the skinned position (Q16.16, saturated) once per vertex,
// after the request marked is_last.
// Each term is worked through one 18x44 multiplier and one accumulator
// under a microcoded sequencer: 24 products over 28 steps. A request is
// taken in the idle state, sequenced through the run steps and finished in
// the finish state, after which i_req.ready returns; the result of a last
// term goes to the output register in its finish step. A new term is not
// taken until the previous one is finished.
// The finished result sits in an output register; the next vertex is worked
// on while it waits. If the receiver still holds the previous result when a
// new one is done, the unit waits in its finish step until o_rsp.ready.
// Reset (synchronous, active low) clears the three position accumulators,
// drops o_rsp.valid and raises i_req.ready.
module weighted_vertex_skinning_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wvs_stream_if.sink   i_req,
    wvs_stream_if.source o_rsp
);
    import wvs_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH} t_state;

    t_state                  r_state;
    logic [STEP_W-1:0]       r_step;
    t_in_data                r_in;
    logic signed [T_W-1:0]   r_tx;
    logic signed [T_W-1:0]   r_ty;
    logic signed [T_W-1:0]   r_tz;
    logic signed [S_W-1:0]   r_s;
    logic signed [ACC_W-1:0] r_acc_x;
    logic signed [ACC_W-1:0] r_acc_y;
    logic signed [ACC_W-1:0] r_acc_z;
    logic                    r_out_valid;
    t_out_data               r_out_data;

    t_uop                    w_uop;
    t_mac_req                w_req;
    logic signed [A_W-1:0]   w_a;
    logic signed [B_W-1:0]   w_b;
    logic signed [MAC_W-1:0] w_base;
    logic signed [MAC_W-1:0] w_sum;
    t_wb                     w_wb;
    logic signed [ACC_W-1:0] w_acc_new;
    logic                    w_accept;
    logic                    w_emit;
    t_out_data               w_out;

    function automatic logic signed [ACC_W-1:0] f_sat_acc(
        input logic signed [MAC_W-1:0] v
    );
        logic [MAC_W-ACC_SHIFT-ACC_W:0] top;
        top = v[MAC_W-1:ACC_SHIFT+ACC_W-1];
        if ((top == '0) || (top == '1)) begin
            return v[ACC_SHIFT +: ACC_W];
        end else if (v[MAC_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] f_sat_out(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-OUT_W:0] top;
        top = v[ACC_W-1:OUT_W-1];
        if ((top == '0) || (top == '1)) begin
            return v[OUT_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

    assign w_accept = i_req.valid && (r_state == S_IDLE);
    assign w_emit   = (r_state == S_FINISH) && r_in.is_last
                      && (!r_out_valid || o_rsp.ready);

    assign w_uop = f_uop(r_step);

    always_comb begin
        if (r_state == S_RUN) begin
            w_req.op = w_uop.op;
            w_req.wb = w_uop.wb;
        end else begin
            w_req.op = OP_NONE;
            w_req.wb = WB_NONE;
        end
    end

    always_comb begin
        case (w_uop.a_sel)
            A_QX:    w_a = {{(A_W-16){r_in.rot_x[15]}}, r_in.rot_x};
            A_QY:    w_a = {{(A_W-16){r_in.rot_y[15]}}, r_in.rot_y};
            A_QZ:    w_a = {{(A_W-16){r_in.rot_z[15]}}, r_in.rot_z};
            A_QW:    w_a = {{(A_W-16){r_in.rot_w[15]}}, r_in.rot_w};
            A_K:     w_a = A_W'(1 << S_SHIFT);
            A_BIAS:  w_a = {{(A_W-17){1'b0}}, r_in.bias};
            default: w_a = '0;
        endcase
    end

    always_comb begin
        case (w_uop.b_sel)
            B_OX:    w_b = {{(B_W-32){r_in.offset_x[31]}}, r_in.offset_x};
            B_OY:    w_b = {{(B_W-32){r_in.offset_y[31]}}, r_in.offset_y};
            B_OZ:    w_b = {{(B_W-32){r_in.offset_z[31]}}, r_in.offset_z};
            B_JX:    w_b = {{(B_W-32){r_in.joint_pos_x[31]}}, r_in.joint_pos_x};
            B_JY:    w_b = {{(B_W-32){r_in.joint_pos_y[31]}}, r_in.joint_pos_y};
            B_JZ:    w_b = {{(B_W-32){r_in.joint_pos_z[31]}}, r_in.joint_pos_z};
            B_TX:    w_b = {{(B_W-T_W){r_tx[T_W-1]}}, r_tx};
            B_TY:    w_b = {{(B_W-T_W){r_ty[T_W-1]}}, r_ty};
            B_TZ:    w_b = {{(B_W-T_W){r_tz[T_W-1]}}, r_tz};
            B_S:     w_b = {{(B_W-S_W){r_s[S_W-1]}}, r_s};
            default: w_b = '0;
        endcase
    end

    // LOAD start values carry the rounding half; the bias step also folds
    // in the running sum, scaled up to line up with the product.
    always_comb begin
        case (w_uop.base)
            BASE_T:  w_base = MAC_W'(1 << (T_SHIFT - 1));
            BASE_S:  w_base = MAC_W'(1 << (S_SHIFT - 1));
            BASE_AX: w_base = {{(MAC_W-ACC_W-ACC_SHIFT){r_acc_x[ACC_W-1]}}, r_acc_x,
                               ACC_SHIFT'(1 << (ACC_SHIFT - 1))};
            BASE_AY: w_base = {{(MAC_W-ACC_W-ACC_SHIFT){r_acc_y[ACC_W-1]}}, r_acc_y,
                               ACC_SHIFT'(1 << (ACC_SHIFT - 1))};
            BASE_AZ: w_base = {{(MAC_W-ACC_W-ACC_SHIFT){r_acc_z[ACC_W-1]}}, r_acc_z,
                               ACC_SHIFT'(1 << (ACC_SHIFT - 1))};
            default: w_base = '0;
        endcase
    end

    wvs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_base  (w_base),
        .i_req   (w_req),
        .o_sum   (w_sum),
        .o_wb    (w_wb)
    );

    assign w_acc_new = f_sat_acc(w_sum);

    always_comb begin
        w_out.out_x = f_sat_out(r_acc_x);
        w_out.out_y = f_sat_out(r_acc_y);
        w_out.out_z = f_sat_out(r_acc_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_acc_z     <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_step  <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(N_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!r_in.is_last) begin
                        r_state <= S_IDLE;
                    end else if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_emit) begin
                r_acc_x <= '0;
                r_acc_y <= '0;
                r_acc_z <= '0;
            end else begin
                case (w_wb)
                    WB_AX:   r_acc_x <= w_acc_new;
                    WB_AY:   r_acc_y <= w_acc_new;
                    WB_AZ:   r_acc_z <= w_acc_new;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_req.data;
        end
        if (w_emit) begin
            r_out_data <= w_out;
        end
        case (w_wb)
            WB_TX:   r_tx <= w_sum[T_SHIFT +: T_W];
            WB_TY:   r_ty <= w_sum[T_SHIFT +: T_W];
            WB_TZ:   r_tz <= w_sum[T_SHIFT +: T_W];
            WB_S:    r_s  <= w_sum[S_SHIFT +: S_W];
            default: ;
        endcase
    end

endmodule

// ===== hdl/wvs_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module wvs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input wvs_pkg::t_out_data i_out_data
);
    import wvs_pkg::*;

    `WVS_ASSERT_RST(a_reset_idle, i_clk, i_rst_n, i_in_ready && !i_out_valid, "bad state after reset")

    `WVS_ASSERT_NEXT(a_one_term, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")

    `WVS_ASSERT_SAME(a_emit_idle, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready && !$past(i_in_ready), "result not posted on return to idle")

    `WVS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")

endmodule

bind weighted_vertex_skinning_unit wvs_checker u_wvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import wvs_pkg::*;

    localparam int     MAX_CYCLES   = 1000000;
    localparam int     DRAIN_CYCLES = 64;
    localparam int     IDLE_PCT     = 32;
    localparam int     HOLD_AT      = 30;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     RANDOM_ITEMS = 1880;
    localparam int     RAMP_AT      = 600;
    localparam int     RAMP_TERMS   = 1100;
    localparam longint ACC_HI       = (longint'(1) <<< 47) - 1;
    localparam longint ACC_LO       = -(longint'(1) <<< 47);
    localparam longint POS_HI       = (longint'(1) <<< 31) - 1;
    localparam longint POS_LO       = -(longint'(1) <<< 31);

    localparam logic signed [15:0] UNIT_ROT [8][4] = '{
        '{16'sd0,     16'sd0,     16'sd0,     16'sd16384},
        '{16'sd16384, 16'sd0,     16'sd0,     16'sd0},
        '{16'sd0,     16'sd16384, 16'sd0,     16'sd0},
        '{16'sd0,     16'sd0,     16'sd16384, 16'sd0},
        '{16'sd11585, 16'sd0,     16'sd0,     16'sd11585},
        '{16'sd0,     16'sd11585, 16'sd0,     16'sd11585},
        '{16'sd0,     16'sd0,     16'sd11585, 16'sd11585},
        '{16'sd8192,  16'sd8192,  16'sd8192,  16'sd8192}
    };

    typedef struct {
        t_in_data  req;
        bit        typed;
        t_out_data want;
    } t_row;

    logic clk;
    logic rst_n;

    wvs_stream_if #(.t_data(t_in_data))  req_if ();
    wvs_stream_if #(.t_data(t_out_data)) rsp_if ();

    weighted_vertex_skinning_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    longint    sum_x;
    longint    sum_y;
    longint    sum_z;
    t_out_data pending_pos[$];
    t_row      rows[$];
    int        mismatches     = 0;
    int        requests_sent  = 0;
    int        positions_seen = 0;
    int        cycles         = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == MAX_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint round_half_up(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // One weight term: rotate offset by quaternion, add joint, scale by bias, accumulate.
    function automatic bit skin_term(input t_in_data d, output t_out_data pos);
        longint jx, jy, jz, qx, qy, qz, qw, ox, oy, oz, b;
        longint tx, ty, tz, rx, ry, rz;
        jx = longint'($signed(d.joint_pos_x));
        jy = longint'($signed(d.joint_pos_y));
        jz = longint'($signed(d.joint_pos_z));
        qx = longint'($signed(d.rot_x));
        qy = longint'($signed(d.rot_y));
        qz = longint'($signed(d.rot_z));
        qw = longint'($signed(d.rot_w));
        ox = longint'($signed(d.offset_x));
        oy = longint'($signed(d.offset_y));
        oz = longint'($signed(d.offset_z));
        b  = longint'({47'd0, d.bias});

        tx = round_half_up(qy * oz - qz * oy, 13);
        ty = round_half_up(qz * ox - qx * oz, 13);
        tz = round_half_up(qx * oy - qy * ox, 13);

        rx = ox + round_half_up(qw * tx + (qy * tz - qz * ty), 14);
        ry = oy + round_half_up(qw * ty + (qz * tx - qx * tz), 14);
        rz = oz + round_half_up(qw * tz + (qx * ty - qy * tx), 14);

        sum_x = clamp(sum_x + round_half_up((jx + rx) * b, 16), ACC_LO, ACC_HI);
        sum_y = clamp(sum_y + round_half_up((jy + ry) * b, 16), ACC_LO, ACC_HI);
        sum_z = clamp(sum_z + round_half_up((jz + rz) * b, 16), ACC_LO, ACC_HI);

        if (!d.is_last) return 1'b0;
        pos.out_x = 32'(clamp(sum_x, POS_LO, POS_HI));
        pos.out_y = 32'(clamp(sum_y, POS_LO, POS_HI));
        pos.out_z = 32'(clamp(sum_z, POS_LO, POS_HI));
        sum_x = 0;
        sum_y = 0;
        sum_z = 0;
        return 1'b1;
    endfunction

    function automatic t_in_data mk_req(
        input int jx, input int jy, input int jz,
        input int qx, input int qy, input int qz, input int qw,
        input int ox, input int oy, input int oz,
        input int b, input bit last
    );
        t_in_data d;
        d.joint_pos_x = jx;
        d.joint_pos_y = jy;
        d.joint_pos_z = jz;
        d.rot_x       = 16'(qx);
        d.rot_y       = 16'(qy);
        d.rot_z       = 16'(qz);
        d.rot_w       = 16'(qw);
        d.offset_x    = ox;
        d.offset_y    = oy;
        d.offset_z    = oz;
        d.bias        = b[16:0];
        d.is_last     = last;
        return d;
    endfunction

    function automatic t_out_data pos_of(input int x, input int y, input int z);
        t_out_data p;
        p.out_x = x;
        p.out_y = y;
        p.out_z = z;
        return p;
    endfunction

    function automatic void add_row(input t_in_data req, input bit typed,
                                    input t_out_data want);
        t_row r;
        r.req   = req;
        r.typed = typed;
        r.want  = want;
        rows.insert(rows.size(), r);
    endfunction

    function automatic logic signed [31:0] rand_pos(input int scale);
        case (scale)
            0:       return $urandom;
            1:       return int'($urandom_range(0, 1 << 25)) - (1 << 24);
            default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_rot(input int kind, input int u, input int c);
        case (kind)
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 32768)) - 16384);
            default: return $urandom_range(0, 1) ? -UNIT_ROT[u][c] : UNIT_ROT[u][c];
        endcase
    endfunction

    function automatic t_in_data random_term(input bit last);
        t_in_data d;
        int       scale;
        int       kind;
        int       u;
        int       pick;
        pick  = $urandom_range(0, 9);
        scale = (pick < 2) ? 0 : (pick < 7) ? 1 : 2;
        pick  = $urandom_range(0, 9);
        kind  = (pick < 2) ? 0 : (pick < 4) ? 1 : 2;
        u     = $urandom_range(0, 7);
        d.joint_pos_x = rand_pos(scale);
        d.joint_pos_y = rand_pos(scale);
        d.joint_pos_z = rand_pos(scale);
        d.offset_x    = rand_pos(scale);
        d.offset_y    = rand_pos(scale);
        d.offset_z    = rand_pos(scale);
        d.rot_x       = rand_rot(kind, u, 0);
        d.rot_y       = rand_rot(kind, u, 1);
        d.rot_z       = rand_rot(kind, u, 2);
        d.rot_w       = rand_rot(kind, u, 3);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            d.bias = 17'($urandom_range(0, 131071));
        else if (pick < 6)
            d.bias = 17'($urandom_range(0, 65536));
        else
            d.bias = 17'd65536 >> $urandom_range(0, 3);
        d.is_last = last;
        return d;
    endfunction

    task automatic send_term(input t_in_data d, input bit typed, input t_out_data want,
                             input bit quiet);
        t_out_data pos;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= d;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        requests_sent++;
        if (skin_term(d, pos)) pending_pos.insert(pending_pos.size(), typed ? want : pos);
    endtask

    // Result side: random stalls, one long hold-off, a stretch with no stalls.
    initial begin
        int        hold;
        bit        quiet;
        bit        bad;
        t_out_data exp_pos;
        hold = 0;
        rsp_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (rsp_if.valid && rsp_if.ready) begin
                positions_seen++;
                if (positions_seen == HOLD_AT) hold = HOLD_CYCLES;
                if (pending_pos.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: unexpected position (%0d, %0d, %0d)",
                                 rsp_if.data.out_x, rsp_if.data.out_y, rsp_if.data.out_z);
                end else begin
                    exp_pos = pending_pos.pop_front();
                    bad = (rsp_if.data.out_x !== exp_pos.out_x) ||
                          (rsp_if.data.out_y !== exp_pos.out_y) ||
                          (rsp_if.data.out_z !== exp_pos.out_z);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "tb: position %0d expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                                positions_seen, exp_pos.out_x, exp_pos.out_y,
                                exp_pos.out_z, rsp_if.data.out_x, rsp_if.data.out_y,
                                rsp_if.data.out_z);
                    end
                end
            end
            quiet = (positions_seen >= 100) && (positions_seen < 200);
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
            @(posedge clk);
        end
    end

    initial begin
        t_out_data blank;
        int        left;
        int        nterms;
        bit        flip;
        t_in_data  ramp;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        blank        = '0;
        sum_x        = 0;
        sum_y        = 0;
        sum_z        = 0;

        add_row(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, pos_of(0, 0, 0));
        add_row(mk_req(0, 0, 0, 0, 0, 0, 16384, 65536, -131072, 196608, 65536, 1'b1),
                1'b1, pos_of(65536, -131072, 196608));
        add_row(mk_req(6553600, 0, -5, 0, 0, 0, 16384, 0, 0, 0, 65536, 1'b1),
                1'b1, pos_of(6553600, 0, -5));
        add_row(mk_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 16384,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 65536, 1'b1),
                1'b1, pos_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        add_row(mk_req(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 16384,
                       32'h80000000, 32'h80000000, 32'h80000000, 65536, 1'b1),
                1'b1, pos_of(32'h80000000, 32'h80000000, 32'h80000000));
        add_row(mk_req(32'h7fffffff, 32'h80000000, 32'h7fffffff, -32768, -32768,
                       -32768, -32768, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       0, 1'b1),
                1'b1, pos_of(0, 0, 0));
        add_row(mk_req(1000, -1000, 7, -32768, -32768, -32768, -32768,
                       32'h7fffffff, 32'h80000000, 12345, 65536, 1'b1),
                1'b0, blank);
        add_row(mk_req(0, 0, 0, 16384, 16384, 16384, 16384, 65536, 131072, 196608,
                       65536, 1'b1),
                1'b0, blank);
        add_row(mk_req(0, 0, 0, 0, 0, 11585, 11585, 65536, 0, 0, 65536, 1'b1),
                1'b0, blank);
        add_row(mk_req(65536, 0, 0, 0, 0, 0, 16384, 65536, 65536, 0, 21845, 1'b0),
                1'b0, blank);
        add_row(mk_req(0, 131072, 0, 16384, 0, 0, 0, 0, 65536, 65536, 21845, 1'b0),
                1'b0, blank);
        add_row(mk_req(0, 0, -196608, 0, 11585, 0, 11585, -65536, 0, 65536, 21846,
                       1'b1),
                1'b0, blank);
        add_row(mk_req(3, -3, 1, 0, 0, 0, 16384, 1 << 20, -(1 << 20), 1 << 21,
                       131071, 1'b1),
                1'b0, blank);
        add_row(mk_req(32'h7fffffff, 32'h80000000, 32'h12345678, 16384, -16384,
                       16384, -16384, 32'h80000000, 32'h7fffffff, 32'hedcba987,
                       131071, 1'b1),
                1'b0, blank);
        add_row(mk_req(0, 0, 0, 16384, 0, 0, 0, 32'h7fffffff, 32'h80000000,
                       32'h12345678, 65536, 1'b1),
                1'b0, blank);
        add_row(mk_req(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 16384, 0, 0, 0,
                       65536, 1'b0),
                1'b0, blank);
        add_row(mk_req(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 16384, 0, 0, 0,
                       65536, 1'b1),
                1'b0, blank);
        add_row(mk_req(32'h7fff0000, -1, 1, 32767, -1, 1, 32767, 32'h0000ffff,
                       32'hffff0000, 32'h55555555, 65535, 1'b1),
                1'b0, blank);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) send_term(rows[i].req, rows[i].typed, rows[i].want, 1'b0);

        left = RANDOM_ITEMS;
        flip = 1'($urandom_range(0, 1));
        while (left > 0) begin
            if (requests_sent >= RAMP_AT && requests_sent < RAMP_AT + 8) begin
                // long vertex of identical large terms, drives one sum into its rail
                for (int k = 0; k < RAMP_TERMS; k++) begin
                    ramp = flip ?
                        mk_req(32'h7fffffff, 32'h7fffffff, 32'h80000000, -32768, -32768,
                               -32768, -32768, 0, 32'h80000000, 32'h7fffffff, 131071,
                               k == RAMP_TERMS - 1) :
                        mk_req(32'h80000000, 32'h80000000, 32'h7fffffff, -32768, -32768,
                               -32768, -32768, 0, 32'h7fffffff, 32'h80000001, 131071,
                               k == RAMP_TERMS - 1);
                    send_term(ramp, 1'b0, blank, 1'b0);
                end
                left -= RAMP_TERMS;
            end else begin
                nterms = $urandom_range(1, 4);
                for (int k = 0; k < nterms; k++)
                    send_term(random_term(k == nterms - 1), 1'b0, blank,
                              requests_sent >= 150 && requests_sent < 450);
                left -= nterms;
            end
        end
        req_if.valid <= 1'b0;

        while (pending_pos.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
